### rtl/pci_bar_aperture_accumulator_defines.svh
// ----------------------------------------------------------------------------
// PCI BAR aperture accumulator assertion macros
// Shared concurrent assertion forms for the checker of the accumulator.
// ----------------------------------------------------------------------------
`ifndef PCI_BAR_APERTURE_ACCUMULATOR_DEFINES_SVH
`define PCI_BAR_APERTURE_ACCUMULATOR_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define PBAA_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pbaa assertion failed");

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define PBAA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pbaa assertion failed");

`endif

### rtl/pbaa_pkg.sv
// ----------------------------------------------------------------------------
// PCI BAR aperture accumulator package
// Decode masks, result kind codes and the internal request record.
// ----------------------------------------------------------------------------
package pbaa_pkg;

    localparam logic [31:0] IO_MASK     = 32'hffff_fffc;
    localparam logic [31:0] MEM_MASK    = 32'hffff_fff0;
    localparam logic [32:0] LOW16_MASK  = 33'h0_0000_ffff;
    localparam logic [31:0] HIGH16_MASK = 32'hffff_0000;
    localparam logic [32:0] IO_GRAIN    = 33'h0_0000_0004;
    localparam logic [63:0] FOUR_GIB    = 64'h0000_0001_0000_0000;
    localparam logic [63:0] EMPTY_BASE  = 64'hffff_ffff_ffff_ffff;
    localparam logic [63:0] EMPTY_LIMIT = 64'h0000_0000_0000_0000;

    typedef enum logic [1:0] {
        KIND_NONE  = 2'd0,
        KIND_IO    = 2'd1,
        KIND_MEM32 = 2'd2,
        KIND_MEM64 = 2'd3
    } bar_kind_t;

    typedef enum logic [1:0] {
        SEL_NONE = 2'd0,
        SEL_IO   = 2'd1,
        SEL_MEM  = 2'd2,
        SEL_HIGH = 2'd3
    } aperture_sel_t;

    typedef struct packed {
        logic          clear;
        aperture_sel_t sel;
        bar_kind_t     kind;
        logic          upper;
        logic [63:0]   base;
        logic [63:0]   limit;
    } bar_req_t;

endpackage

### rtl/pci_bar_aperture_accumulator.sv
// ----------------------------------------------------------------------------
// PCI BAR aperture accumulator
// Decodes probed BARs and widens the I/O, low and high memory apertures.
// ----------------------------------------------------------------------------
// Usage: each input request carries one command. A clear command empties all
// three apertures for a new root bridge; a probe command carries the original
// and all-ones readback of a BAR (plus the next slot for 64-bit memory BARs)
// and the device decode enables. Requests enter on in_valid/in_ready and
// every request produces exactly one result on out_valid/out_ready: the six
// aperture bounds after the update, the decoded BAR kind and whether the next
// slot was used as the upper half.
// The BAR is decoded into base and limit ahead of the request register, and
// the update stage then compares against the stored apertures, updates them
// and registers the result. One request is taken every cycle while the
// receiver keeps taking results.
// When the receiver stalls, the result and the aperture state hold and the
// decode register fills; in_ready then drops until the result is taken.
// Reset empties all apertures (base all ones, limit zero) and both stages.
// ----------------------------------------------------------------------------
module pci_bar_aperture_accumulator (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        cmd,
    input  logic [31:0] orig_low,
    input  logic [31:0] probe_low,
    input  logic [31:0] orig_high,
    input  logic [31:0] probe_high,
    input  logic [1:0]  decode_enables,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [63:0] io_lo,
    output logic [63:0] io_hi,
    output logic [63:0] mem_lo,
    output logic [63:0] mem_hi,
    output logic [63:0] high_lo,
    output logic [63:0] high_hi,
    output logic [1:0]  bar_kind,
    output logic        upper_used
);

    pbaa_pkg::bar_req_t dec_req;
    pbaa_pkg::bar_req_t s1_reg;
    logic               s1_valid_reg;
    logic               s1_valid_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic               advance;
    logic               in_fire;
    logic               update;

    logic [32:0] io_len;
    logic [31:0] mem32_len;
    logic [63:0] mem64_size;
    logic [63:0] sel_base;
    logic [63:0] sel_len;

    logic [63:0] io_lo_reg,   io_lo_next;
    logic [63:0] io_hi_reg,   io_hi_next;
    logic [63:0] mem_lo_reg,  mem_lo_next;
    logic [63:0] mem_hi_reg,  mem_hi_next;
    logic [63:0] high_lo_reg, high_lo_next;
    logic [63:0] high_hi_reg, high_hi_next;
    logic [1:0]  kind_reg;
    logic        upper_reg;
    logic        grows;

    assign advance  = !out_valid_reg || out_ready;
    assign in_ready = !s1_valid_reg || advance;
    assign in_fire  = in_valid && in_ready;
    assign update   = advance && s1_valid_reg;

    // The decode stage turns the probe into a base and an inclusive limit.
    always_comb
    begin
        io_len = {1'b0, ~probe_low & pbaa_pkg::IO_MASK} + pbaa_pkg::IO_GRAIN;
        if ((probe_low & pbaa_pkg::HIGH16_MASK) == 32'd0)
        begin
            io_len = io_len & pbaa_pkg::LOW16_MASK;
        end
        mem32_len  = ~(probe_low & pbaa_pkg::MEM_MASK) + 32'd1;
        mem64_size = {probe_high, probe_low & pbaa_pkg::MEM_MASK};

        dec_req       = '0;
        dec_req.clear = !cmd;
        dec_req.sel   = pbaa_pkg::SEL_NONE;
        dec_req.kind  = pbaa_pkg::KIND_NONE;
        sel_base      = {32'd0, orig_low & pbaa_pkg::MEM_MASK};
        sel_len       = {32'd0, mem32_len};

        if (cmd && (probe_low != 32'd0))
        begin
            if (probe_low[0])
            begin
                sel_base = {32'd0, orig_low & pbaa_pkg::IO_MASK};
                sel_len  = {31'd0, io_len};
                if (decode_enables[0])
                begin
                    dec_req.sel  = pbaa_pkg::SEL_IO;
                    dec_req.kind = pbaa_pkg::KIND_IO;
                end
            end
            else if (decode_enables[1])
            begin
                if (probe_low[2:1] == 2'b00)
                begin
                    dec_req.sel  = pbaa_pkg::SEL_MEM;
                    dec_req.kind = pbaa_pkg::KIND_MEM32;
                end
                else
                begin
                    sel_base      = {orig_high, orig_low & pbaa_pkg::MEM_MASK};
                    sel_len       = ~mem64_size + 64'd1;
                    dec_req.kind  = pbaa_pkg::KIND_MEM64;
                    dec_req.upper = 1'b1;
                    if (sel_base < pbaa_pkg::FOUR_GIB)
                    begin
                        dec_req.sel = pbaa_pkg::SEL_MEM;
                    end
                    else
                    begin
                        dec_req.sel = pbaa_pkg::SEL_HIGH;
                    end
                end
            end
        end

        dec_req.base  = sel_base;
        dec_req.limit = sel_base + sel_len - 64'd1;
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_fire)
        begin
            s1_valid_next = 1'b1;
        end
        else if (advance)
        begin
            s1_valid_next = 1'b0;
        end
        out_valid_next = advance ? s1_valid_reg : out_valid_reg;
    end

    // A clear empties all apertures; a proper range widens the selected one.
    always_comb
    begin
        grows        = s1_reg.base < s1_reg.limit;
        io_lo_next   = io_lo_reg;
        io_hi_next   = io_hi_reg;
        mem_lo_next  = mem_lo_reg;
        mem_hi_next  = mem_hi_reg;
        high_lo_next = high_lo_reg;
        high_hi_next = high_hi_reg;
        if (update)
        begin
            if (s1_reg.clear)
            begin
                io_lo_next   = pbaa_pkg::EMPTY_BASE;
                io_hi_next   = pbaa_pkg::EMPTY_LIMIT;
                mem_lo_next  = pbaa_pkg::EMPTY_BASE;
                mem_hi_next  = pbaa_pkg::EMPTY_LIMIT;
                high_lo_next = pbaa_pkg::EMPTY_BASE;
                high_hi_next = pbaa_pkg::EMPTY_LIMIT;
            end
            else if (grows)
            begin
                unique case (s1_reg.sel)
                    pbaa_pkg::SEL_IO:
                    begin
                        if (io_lo_reg > s1_reg.base)
                        begin
                            io_lo_next = s1_reg.base;
                        end
                        if (io_hi_reg < s1_reg.limit)
                        begin
                            io_hi_next = s1_reg.limit;
                        end
                    end
                    pbaa_pkg::SEL_MEM:
                    begin
                        if (mem_lo_reg > s1_reg.base)
                        begin
                            mem_lo_next = s1_reg.base;
                        end
                        if (mem_hi_reg < s1_reg.limit)
                        begin
                            mem_hi_next = s1_reg.limit;
                        end
                    end
                    pbaa_pkg::SEL_HIGH:
                    begin
                        if (high_lo_reg > s1_reg.base)
                        begin
                            high_lo_next = s1_reg.base;
                        end
                        if (high_hi_reg < s1_reg.limit)
                        begin
                            high_hi_next = s1_reg.limit;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            io_lo_reg     <= pbaa_pkg::EMPTY_BASE;
            io_hi_reg     <= pbaa_pkg::EMPTY_LIMIT;
            mem_lo_reg    <= pbaa_pkg::EMPTY_BASE;
            mem_hi_reg    <= pbaa_pkg::EMPTY_LIMIT;
            high_lo_reg   <= pbaa_pkg::EMPTY_BASE;
            high_hi_reg   <= pbaa_pkg::EMPTY_LIMIT;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            io_lo_reg     <= io_lo_next;
            io_hi_reg     <= io_hi_next;
            mem_lo_reg    <= mem_lo_next;
            mem_hi_reg    <= mem_hi_next;
            high_lo_reg   <= high_lo_next;
            high_hi_reg   <= high_hi_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_reg <= dec_req;
        end
        if (update)
        begin
            kind_reg  <= s1_reg.kind;
            upper_reg <= s1_reg.upper;
        end
    end

    assign out_valid  = out_valid_reg;
    assign io_lo      = io_lo_reg;
    assign io_hi      = io_hi_reg;
    assign mem_lo     = mem_lo_reg;
    assign mem_hi     = mem_hi_reg;
    assign high_lo    = high_lo_reg;
    assign high_hi    = high_hi_reg;
    assign bar_kind   = kind_reg;
    assign upper_used = upper_reg;

endmodule

### rtl/pbaa_checker.sv
// ----------------------------------------------------------------------------
// PCI BAR aperture accumulator checker
// Port-level assertions on results and aperture bounds, bound to the top.
// ----------------------------------------------------------------------------
`include "pci_bar_aperture_accumulator_defines.svh"

module pbaa_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [63:0] io_lo,
    input logic [63:0] io_hi,
    input logic [63:0] mem_lo,
    input logic [63:0] mem_hi,
    input logic [63:0] high_lo,
    input logic [63:0] high_hi,
    input logic [1:0]  bar_kind,
    input logic        upper_used
);

    logic         kind_ok;
    logic         io_ok;
    logic         mem_ok;
    logic         stalled;
    logic [386:0] result_view;

    assign kind_ok = upper_used == (bar_kind == pbaa_pkg::KIND_MEM64);
    assign io_ok   = (io_hi == pbaa_pkg::EMPTY_LIMIT) ? (io_lo == pbaa_pkg::EMPTY_BASE)
                                                       : (io_lo < io_hi);
    assign mem_ok  = (mem_hi == pbaa_pkg::EMPTY_LIMIT) ? (mem_lo == pbaa_pkg::EMPTY_BASE)
                                                        : (mem_lo < mem_hi);
    assign stalled = out_valid && !out_ready;
    assign result_view = {io_lo, io_hi, mem_lo, mem_hi, high_lo, high_hi, bar_kind,
                          upper_used};

    // The upper slot is consumed exactly for 64-bit memory BARs.
    `PBAA_ASSERT_IMPLIES(a_upper_kind, clk, rst_n, out_valid, kind_ok)

    // An aperture is either empty in both bounds or holds a proper range.
    `PBAA_ASSERT_IMPLIES(a_io_range, clk, rst_n, out_valid, io_ok)

    `PBAA_ASSERT_IMPLIES(a_mem_range, clk, rst_n, out_valid, mem_ok)

    // A stalled result keeps every field.
    `PBAA_ASSERT_NEXT(a_stall_hold, clk, rst_n, stalled, out_valid && $stable(result_view))

endmodule

bind pci_bar_aperture_accumulator pbaa_checker u_pbaa_checker (.*);

### verif/tb_pci_bar_aperture_accumulator.sv
// ----------------------------------------------------------------------------
// PCI BAR aperture accumulator testbench
// Sends directed and random BAR probes and clear commands through the
// valid/ready request channel, predicts the three apertures in the bench and
// compares every result field against the oldest predicted result. Both the
// request and the result side insert random gaps.
// ----------------------------------------------------------------------------
module tb_pci_bar_aperture_accumulator;

    localparam logic       CMD_CLEAR = 1'b0;
    localparam logic       CMD_PROBE = 1'b1;
    localparam logic [1:0] EN_NONE   = 2'b00;
    localparam logic [1:0] EN_IO     = 2'b01;
    localparam logic [1:0] EN_MEM    = 2'b10;
    localparam logic [1:0] EN_BOTH   = 2'b11;
    localparam logic [1:0] TYPE_32   = 2'b00;
    localparam logic [1:0] TYPE_RSVD = 2'b01;
    localparam logic [1:0] TYPE_64   = 2'b10;
    localparam logic [1:0] TYPE_ODD  = 2'b11;

    typedef struct packed {
        logic [63:0]          io_lo;
        logic [63:0]          io_hi;
        logic [63:0]          mem_lo;
        logic [63:0]          mem_hi;
        logic [63:0]          high_lo;
        logic [63:0]          high_hi;
        pbaa_pkg::bar_kind_t  kind;
        logic                 upper;
    } aperture_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic        cmd = 1'b0;
    logic [31:0] orig_low = '0;
    logic [31:0] probe_low = '0;
    logic [31:0] orig_high = '0;
    logic [31:0] probe_high = '0;
    logic [1:0]  decode_enables = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [63:0] io_lo;
    logic [63:0] io_hi;
    logic [63:0] mem_lo;
    logic [63:0] mem_hi;
    logic [63:0] high_lo;
    logic [63:0] high_hi;
    logic [1:0]  bar_kind;
    logic        upper_used;

    logic [63:0] ap_io_base = pbaa_pkg::EMPTY_BASE;
    logic [63:0] ap_io_limit = pbaa_pkg::EMPTY_LIMIT;
    logic [63:0] ap_mem_base = pbaa_pkg::EMPTY_BASE;
    logic [63:0] ap_mem_limit = pbaa_pkg::EMPTY_LIMIT;
    logic [63:0] ap_high_base = pbaa_pkg::EMPTY_BASE;
    logic [63:0] ap_high_limit = pbaa_pkg::EMPTY_LIMIT;

    aperture_result_t pending_apertures[$];
    int unsigned      mismatch_count = 0;
    bit               sender_steady = 1'b0;

    pci_bar_aperture_accumulator dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .cmd            (cmd),
        .orig_low       (orig_low),
        .probe_low      (probe_low),
        .orig_high      (orig_high),
        .probe_high     (probe_high),
        .decode_enables (decode_enables),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .io_lo          (io_lo),
        .io_hi          (io_hi),
        .mem_lo         (mem_lo),
        .mem_hi         (mem_hi),
        .high_lo        (high_lo),
        .high_hi        (high_hi),
        .bar_kind       (bar_kind),
        .upper_used     (upper_used)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic logic [127:0] stretch(logic [63:0] lo, logic [63:0] hi,
                                             logic [63:0] base, logic [63:0] length);
        logic [63:0] limit;
        limit = base + length - 64'd1;
        if (base < limit)
        begin
            if (lo > base)
                lo = base;
            if (hi < limit)
                hi = limit;
        end
        return {lo, hi};
    endfunction

    function automatic aperture_result_t predict_aperture(logic c, logic [31:0] ol,
                                                          logic [31:0] pl, logic [31:0] oh,
                                                          logic [31:0] ph, logic [1:0] en);
        aperture_result_t r;
        logic [63:0]      base;
        logic [63:0]      size;
        logic [63:0]      length;
        logic [31:0]      size32;
        r.kind  = pbaa_pkg::KIND_NONE;
        r.upper = 1'b0;
        if (c == CMD_CLEAR)
        begin
            ap_io_base    = pbaa_pkg::EMPTY_BASE;
            ap_io_limit   = pbaa_pkg::EMPTY_LIMIT;
            ap_mem_base   = pbaa_pkg::EMPTY_BASE;
            ap_mem_limit  = pbaa_pkg::EMPTY_LIMIT;
            ap_high_base  = pbaa_pkg::EMPTY_BASE;
            ap_high_limit = pbaa_pkg::EMPTY_LIMIT;
        end
        else if (pl != 32'd0)
        begin
            if (pl[0])
            begin
                if (en[0])
                begin
                    base   = {32'd0, ol & pbaa_pkg::IO_MASK};
                    length = {32'd0, ~pl & pbaa_pkg::IO_MASK} + pbaa_pkg::IO_GRAIN;
                    if ((pl & pbaa_pkg::HIGH16_MASK) == 32'd0)
                        length[63:16] = '0;
                    {ap_io_base, ap_io_limit} = stretch(ap_io_base, ap_io_limit, base, length);
                    r.kind = pbaa_pkg::KIND_IO;
                end
            end
            else if (en[1])
            begin
                base = {32'd0, ol & pbaa_pkg::MEM_MASK};
                size = {32'd0, pl & pbaa_pkg::MEM_MASK};
                if (pl[2:1] == TYPE_32)
                begin
                    size32 = -size[31:0];
                    length = {32'd0, size32};
                    {ap_mem_base, ap_mem_limit} =
                        stretch(ap_mem_base, ap_mem_limit, base, length);
                    r.kind = pbaa_pkg::KIND_MEM32;
                end
                else
                begin
                    base[63:32] = oh;
                    size[63:32] = ph;
                    length      = -size;
                    if (base < pbaa_pkg::FOUR_GIB)
                        {ap_mem_base, ap_mem_limit} =
                            stretch(ap_mem_base, ap_mem_limit, base, length);
                    else
                        {ap_high_base, ap_high_limit} =
                            stretch(ap_high_base, ap_high_limit, base, length);
                    r.kind  = pbaa_pkg::KIND_MEM64;
                    r.upper = 1'b1;
                end
            end
        end
        r.io_lo   = ap_io_base;
        r.io_hi   = ap_io_limit;
        r.mem_lo  = ap_mem_base;
        r.mem_hi  = ap_mem_limit;
        r.high_lo = ap_high_base;
        r.high_hi = ap_high_limit;
        return r;
    endfunction

    function automatic int unsigned idle_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        else if (roll < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got)
        begin
            $error("%s mismatch: expected %h, actual %h", name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge clk)
    begin : result_checker
        aperture_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_apertures.size() == 0)
            begin
                $error("result arrived with no request outstanding");
                mismatch_count++;
            end
            else
            begin
                want = pending_apertures.pop_front();
                check_field("io_lo", want.io_lo, io_lo);
                check_field("io_hi", want.io_hi, io_hi);
                check_field("mem_lo", want.mem_lo, mem_lo);
                check_field("mem_hi", want.mem_hi, mem_hi);
                check_field("high_lo", want.high_lo, high_lo);
                check_field("high_hi", want.high_hi, high_hi);
                check_field("bar_kind", {62'd0, want.kind}, {62'd0, bar_kind});
                check_field("upper_used", {63'd0, want.upper}, {63'd0, upper_used});
            end
        end
    end

    initial
    begin : result_stall
        int unsigned gap;
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            out_ready <= 1'b1;
            if ($urandom_range(0, 9) == 0)
                repeat ($urandom_range(100, 300)) @(posedge clk);
            else
                repeat ($urandom_range(1, 30)) @(posedge clk);
            gap = idle_gap();
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    end

    // Called at a rising edge; returns at the edge where the request was taken
    // or at the end of the gap that follows it, with valid left high otherwise.
    task automatic send_request(logic c, logic [31:0] ol, logic [31:0] pl,
                                logic [31:0] oh, logic [31:0] ph, logic [1:0] en);
        int unsigned gap;
        cmd            <= c;
        orig_low       <= ol;
        probe_low      <= pl;
        orig_high      <= oh;
        probe_high     <= ph;
        decode_enables <= en;
        in_valid       <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        pending_apertures.push_back(predict_aperture(c, ol, pl, oh, ph, en));
        gap = sender_steady ? 0 : idle_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic wait_for_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_apertures.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_reset_and_skip();
        send_request(CMD_PROBE, 32'h1234_5678, 32'h0000_0000, 32'h0, 32'h0, EN_BOTH);
        send_request(CMD_PROBE, 32'h0000_0000, 32'h0000_0000, 32'h0, 32'h0, EN_NONE);
        send_request(CMD_PROBE, 32'hffff_ffff, 32'h0000_0000, 32'hffff_ffff,
                     32'hffff_ffff, EN_BOTH);
    endtask

    task automatic test_io_bars();
        send_request(CMD_PROBE, 32'h0000_c001, 32'h0000_ff01, 32'h0, 32'h0, EN_IO);
        send_request(CMD_PROBE, 32'h1234_5601, 32'hffff_ff01, 32'h0, 32'h0, EN_BOTH);
        send_request(CMD_PROBE, 32'h0000_e001, 32'hffff_fffd, 32'h0, 32'h0, EN_IO);
        send_request(CMD_PROBE, 32'h0000_d001, 32'h0001_0001, 32'h0, 32'h0, EN_IO);
        send_request(CMD_PROBE, 32'h0000_b001, 32'h0000_ff01, 32'h0, 32'h0, EN_MEM);
        send_request(CMD_PROBE, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
                     32'hffff_ffff, EN_BOTH);
        // A 16-bit decoder whose length clamps to zero wraps the limit.
        send_request(CMD_PROBE, 32'h0000_0000, 32'h0000_0001, 32'h0, 32'h0, EN_IO);
        send_request(CMD_CLEAR, 32'h0, 32'h0, 32'h0, 32'h0, EN_NONE);
    endtask

    task automatic test_mem32_bars();
        send_request(CMD_PROBE, 32'hfebf_0000, 32'hffff_0000, 32'h0, 32'h0, EN_MEM);
        send_request(CMD_PROBE, 32'hc000_0008, 32'hfff0_0008, 32'h0, 32'h0, EN_BOTH);
        send_request(CMD_PROBE, 32'h8000_0000, 32'hff00_0000, 32'h0, 32'h0, EN_IO);
        send_request(CMD_PROBE, 32'hffff_fff0, 32'hffff_fff0, 32'h0, 32'h0, EN_MEM);
        send_request(CMD_PROBE, 32'h0000_0000, 32'h0000_0008, 32'h0, 32'h0, EN_MEM);
    endtask

    task automatic test_mem64_bars();
        send_request(CMD_PROBE, 32'he000_000c, 32'hf000_000c, 32'h0, 32'hffff_ffff, EN_MEM);
        send_request(CMD_PROBE, 32'h0000_000c, 32'h0000_000c, 32'h0000_0008,
                     32'hffff_fff0, EN_MEM);
        send_request(CMD_PROBE, 32'h0010_0002, 32'hfff0_0002, 32'h0000_0010,
                     32'hffff_ffff, EN_BOTH);
        send_request(CMD_PROBE, 32'h0000_0006, 32'h0000_0006, 32'h8000_0000,
                     32'hffff_ffff, EN_MEM);
        send_request(CMD_PROBE, 32'h0000_0004, 32'h0000_0004, 32'h0000_0000,
                     32'h8000_0000, EN_MEM);
        send_request(CMD_PROBE, 32'hfffffff0, 32'hfffffff4, 32'hffff_ffff,
                     32'hffff_ffff, EN_MEM);
        send_request(CMD_PROBE, 32'h0000_000c, 32'hffff_000c, 32'h0000_0100,
                     32'hffff_ffff, EN_IO);
    endtask

    task automatic test_clear_command();
        send_request(CMD_CLEAR, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
                     32'hffff_ffff, EN_BOTH);
        send_request(CMD_PROBE, 32'h0000_1001, 32'hffff_fff1, 32'h0, 32'h0, EN_IO);
    endtask

    task automatic send_random_bar();
        logic        c;
        logic [31:0] ol;
        logic [31:0] pl;
        logic [31:0] oh;
        logic [31:0] ph;
        logic [1:0]  en;
        logic [31:0] mask32;
        logic [63:0] mask64;
        logic [63:0] base64;
        int unsigned pick;
        int unsigned sh;
        c    = CMD_PROBE;
        ol   = $urandom;
        pl   = $urandom;
        oh   = $urandom;
        ph   = $urandom;
        en   = ($urandom_range(0, 9) == 0) ? 2'($urandom_range(0, 3)) : EN_BOTH;
        pick = $urandom_range(0, 99);
        if (pick < 2)
        begin
            c = CMD_CLEAR;
        end
        else if (pick < 12)
        begin
            c  = 1'($urandom_range(0, 19) != 0);
            en = 2'($urandom_range(0, 3));
        end
        else if (pick < 37)
        begin
            sh     = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 31) : $urandom_range(2, 8);
            mask32 = ~((32'd1 << sh) - 32'd1);
            pl     = mask32 | 32'd1;
            if ($urandom_range(0, 1) == 0)
                pl[31:16] = '0;
            if ($urandom_range(0, 3) != 0)
                ol = ol & 32'h0000_ffff;
            ol = (ol & mask32) | 32'd1;
        end
        else if (pick < 67)
        begin
            sh     = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 31) : $urandom_range(4, 24);
            mask32 = ~((32'd1 << sh) - 32'd1);
            pl     = mask32 | {28'd0, 1'($urandom_range(0, 1)), 3'b000};
            ol     = ol & mask32;
        end
        else
        begin
            sh     = ($urandom_range(0, 4) == 0) ? $urandom_range(33, 63) : $urandom_range(4, 32);
            mask64 = ~((64'd1 << sh) - 64'd1);
            base64 = {oh, ol} & mask64;
            if ($urandom_range(0, 1) == 0)
                base64[63:32] = '0;
            pl      = mask64[31:0];
            pl[3]   = 1'($urandom_range(0, 1));
            pl[2:1] = ($urandom_range(0, 9) == 0) ?
                      (($urandom_range(0, 1) == 0) ? TYPE_RSVD : TYPE_ODD) : TYPE_64;
            ph      = mask64[63:32];
            ol      = base64[31:0] | {28'd0, pl[3:0]};
            oh      = base64[63:32];
        end
        send_request(c, ol, pl, oh, ph, en);
    endtask

    task automatic test_random_bars();
        for (int i = 0; i < 1700; i++)
        begin
            if (i % 100 == 0)
                sender_steady = ($urandom_range(0, 3) == 0);
            if (i == 850)
                wait_for_results();
            send_random_bar();
        end
        sender_steady = 1'b0;
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_and_skip();
        test_io_bars();
        test_mem32_bars();
        test_mem64_bars();
        test_clear_command();
        wait_for_results();
        test_random_bars();
        wait_for_results();
        repeat (8) @(posedge clk);
        if (mismatch_count == 0)
            $display("** pci_bar_aperture_accumulator: PASSED **");
        else
            $display("** pci_bar_aperture_accumulator: FAILED **");
        $finish;
    end

    initial
    begin
        #12_000_000;
        $display("** pci_bar_aperture_accumulator: FAILED **");
        $finish;
    end

endmodule
